// File: rtl/gsbd_pkg.sv
// Shared types, constants and helpers for the signed Golomb bit decoder.
package gsbd_pkg;

    localparam int QUOTIENT_MAX = 4095;
    localparam int DIVISOR_BITS = 16;

    localparam int QCNT_W  = 12;   // quotient count
    localparam int MAG_W   = 28;   // magnitude / q*m accumulator
    localparam int VALUE_W = 29;   // signed result
    localparam int BITS_W  = 5;    // remainder bit counter and ceil(log2 m)

    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

    localparam logic [1:0] PH_QUOT   = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_EXTRA  = 2'd2;
    localparam logic [1:0] PH_SIGN   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EOS      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Divisor and the values derived from it at write time.
    typedef struct packed {
        logic [DIVISOR_BITS-1:0] m;       // effective divisor, at least 2
        logic [BITS_W-1:0]       ceil_b;  // ceil(log2 m)
        logic [DIVISOR_BITS-1:0] lofs;    // 2^b - m
    } t_div_cfg;

    // Per-symbol decode state.
    typedef struct packed {
        logic [1:0]              phase;
        logic [QCNT_W-1:0]       qcount;
        logic [MAG_W-1:0]        qm;      // running qcount * m
        logic [DIVISOR_BITS-1:0] acc;
        logic [BITS_W-1:0]       bits;
        logic [MAG_W-1:0]        hold;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:  PH_QUOT,
        qcount: '0,
        qm:     '0,
        acc:    '0,
        bits:   '0,
        hold:   '0
    };

endpackage

// File: rtl/golomb_signed_bit_decoder_unit.sv
// Top level: signed Golomb decoder with truncated-binary remainder, one coded bit per beat.
// A bit sits in the input register, then its result (if any) is registered in the result
//   register; the held bit waits there while the result register is full and not drained.
// Throughput: one input beat per cycle, sustained while the output side keeps taking beats.
// Reset: i_rst_n is synchronous, active low; it empties both registers, clears the symbol
//   state and sets the divisor to 2. A divisor write also clears the symbol state.
module golomb_signed_bit_decoder_unit import gsbd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_divisor_we,
    input  logic [DIVISOR_BITS-1:0]   i_divisor,
    // input beats
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_coded_bit,
    input  logic                      i_end_of_stream,
    // result beats
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [1:0]                o_status
);

    t_div_cfg cfg;

    // input register
    logic r_in_valid;
    logic r_in_bit;
    logic r_in_eos;

    // symbol state
    t_state r_state;
    t_state n_state;

    // result register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [1:0]                r_out_status;

    logic                      step_emit;
    logic signed [VALUE_W-1:0] step_value;
    logic [1:0]                step_status;

    logic out_free;
    logic proc;
    logic in_take;

    gsbd_divisor u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_divisor_we (i_divisor_we),
        .i_divisor    (i_divisor),
        .o_cfg        (cfg)
    );

    gsbd_step u_step (
        .i_cfg           (cfg),
        .i_state         (r_state),
        .i_coded_bit     (r_in_bit),
        .i_end_of_stream (r_in_eos),
        .o_state         (n_state),
        .o_emit          (step_emit),
        .o_value         (step_value),
        .o_status        (step_status)
    );

    // The held bit is worked off only when the result register is free or being
    // drained, whether or not it yields a result; this keeps results in order.
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || proc;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_bit <= i_coded_bit;
            r_in_eos <= i_end_of_stream;
        end
    end

    // state: divisor write aborts any symbol in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_divisor_we) begin
            r_state <= STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && step_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && step_emit) begin
            r_out_value  <= step_value;
            r_out_status <= step_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

endmodule

// File: rtl/gsbd_divisor.sv
// Divisor register with registered ceil(log2 m) and truncated-binary offset.
module gsbd_divisor import gsbd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_divisor_we,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output t_div_cfg                o_cfg
);

    t_div_cfg r_cfg;
    t_div_cfg n_cfg;

    logic [DIVISOR_BITS-1:0] eff_m;
    logic [DIVISOR_BITS:0]   pow_b;

    always_comb begin
        eff_m = (i_divisor < DIVISOR_BITS'(2)) ? DIVISOR_BITS'(2) : i_divisor;
        n_cfg.m = eff_m;
        n_cfg.ceil_b = '0;
        // independent compares; the last one that holds wins
        for (int i = 0; i < DIVISOR_BITS; i++) begin
            if (((DIVISOR_BITS+1)'(1) << i) < {1'b0, eff_m}) begin
                n_cfg.ceil_b = BITS_W'(i + 1);
            end
        end
        pow_b = (DIVISOR_BITS+1)'(1) << n_cfg.ceil_b;
        n_cfg.lofs = DIVISOR_BITS'(pow_b - {1'b0, eff_m});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m      <= DIVISOR_BITS'(2);
            r_cfg.ceil_b <= BITS_W'(1);
            r_cfg.lofs   <= '0;
        end else if (i_divisor_we) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/gsbd_step.sv
// Per-bit decode step: next symbol state and the result it may produce.
module gsbd_step import gsbd_pkg::*; (
    input  t_div_cfg                  i_cfg,
    input  t_state                    i_state,
    input  logic                      i_coded_bit,
    input  logic                      i_end_of_stream,
    output t_state                    o_state,
    output logic                      o_emit,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [1:0]                o_status
);

    logic [DIVISOR_BITS-1:0] pre_acc;
    logic [BITS_W-1:0]       pre_bits;
    logic [DIVISOR_BITS:0]   full;
    logic [DIVISOR_BITS-1:0] rem;
    logic [DIVISOR_BITS-1:0] fin_r;
    logic                    do_finish;
    logic [MAG_W:0]          mag;

    always_comb begin
        o_state   = i_state;
        o_emit    = 1'b0;
        o_value   = '0;
        o_status  = ST_OK;
        do_finish = 1'b0;
        fin_r     = '0;

        pre_acc  = {i_state.acc[DIVISOR_BITS-2:0], i_coded_bit};
        pre_bits = i_state.bits + BITS_W'(1);
        full     = {i_state.acc, i_coded_bit};
        rem      = (full >= {1'b0, i_cfg.lofs})
                   ? DIVISOR_BITS'(full - {1'b0, i_cfg.lofs}) : '0;

        if (i_end_of_stream) begin
            o_emit   = 1'b1;
            o_status = ST_EOS;
            o_state  = STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_QUOT: begin
                    if (!i_coded_bit) begin
                        if (i_state.qcount >= QCNT_W'(QUOTIENT_MAX)) begin
                            o_emit   = 1'b1;
                            o_status = ST_OVERFLOW;
                            o_state  = STATE_RESET;
                        end else begin
                            o_state.qcount = i_state.qcount + QCNT_W'(1);
                            o_state.qm     = i_state.qm + MAG_W'(i_cfg.m);
                        end
                    end else begin
                        o_state.acc  = '0;
                        o_state.bits = '0;
                        // b == 1 means m == 2: offset is zero, extra bit always follows
                        o_state.phase = (i_cfg.ceil_b <= BITS_W'(1)) ? PH_EXTRA : PH_PREFIX;
                    end
                end
                PH_PREFIX: begin
                    o_state.acc  = pre_acc;
                    o_state.bits = pre_bits;
                    if ({1'b0, pre_bits} + 6'd1 >= {1'b0, i_cfg.ceil_b}) begin
                        if (pre_acc >= i_cfg.lofs) begin
                            o_state.phase = PH_EXTRA;
                        end else begin
                            do_finish = 1'b1;
                            fin_r     = pre_acc;
                        end
                    end
                end
                PH_EXTRA: begin
                    do_finish = 1'b1;
                    fin_r     = rem;
                end
                PH_SIGN: begin
                    o_emit   = 1'b1;
                    o_value  = i_coded_bit ? (VALUE_W'(0) - VALUE_W'(i_state.hold))
                                           : VALUE_W'(i_state.hold);
                    o_state  = STATE_RESET;
                end
                default: begin
                    o_state = STATE_RESET;
                end
            endcase
        end

        mag = {1'b0, i_state.qm} + (MAG_W+1)'(fin_r);
        if (do_finish) begin
            if (mag > {1'b0, MAG_LIMIT}) begin
                o_emit   = 1'b1;
                o_status = ST_OVERFLOW;
                o_state  = STATE_RESET;
            end else if (mag == '0) begin
                o_emit   = 1'b1;
                o_state  = STATE_RESET;
            end else begin
                o_state.hold  = MAG_W'(mag);
                o_state.phase = PH_SIGN;
            end
        end
    end

endmodule

// File: bench/golomb_signed_bit_decoder_unit_test.sv
// Self-checking bench for the signed Golomb bit decoder: directed rows, random symbols, stalls.
`timescale 1ns / 100ps

module golomb_signed_bit_decoder_unit_test import gsbd_pkg::*;;

    // run shape
    localparam int NUM_DIRECTED    = 22;
    localparam int NUM_PHASES      = 12;
    localparam int PHASE_ITEMS     = 85;     // input beats per random phase
    localparam int DRAIN_CYCLES    = 4;      // covers a bit still held in the input register
    localparam int HOLD_OFF_CYCLES = 80;     // long receiver stall, fills the pipe
    localparam int CYCLE_LIMIT     = 200000; // watchdog bound on the whole run

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // One input beat; has_expect marks a row whose result is typed in by hand.
    typedef struct packed {
        logic                      cbit;
        logic                      eos;
        logic                      has_expect;
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_stim_row;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_sym_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_divisor_we = 1'b0;
    logic [DIVISOR_BITS-1:0]   i_divisor = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_coded_bit = 1'b0;
    logic                      i_end_of_stream = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [VALUE_W-1:0] o_value;
    logic [1:0]                o_status;

    golomb_signed_bit_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_divisor_we    (i_divisor_we),
        .i_divisor       (i_divisor),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_coded_bit     (i_coded_bit),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value         (o_value),
        .o_status        (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder state mirror: divisor register plus per-symbol state.
    // ------------------------------------------------------------------
    logic [DIVISOR_BITS-1:0]   div_reg = 16'd2;
    logic [1:0]                sym_phase = PH_QUOT;
    int unsigned               sym_qcount, sym_bits;
    longint unsigned           sym_acc, sym_hold;
    logic                      sym_fire;
    logic signed [VALUE_W-1:0] sym_value;
    logic [1:0]                sym_status;

    t_sym_result expected_symbols [$];
    t_stim_row   pending_beats [$];

    // driver-side tag of the beat on the bus, read when it is taken
    logic        row_has_expect = 1'b0;
    t_sym_result row_expect = '0;

    t_idle_mode  idle_mode = IDLE_NONE;
    bit          hold_off_req = 1'b0;
    int          phase_items;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    // divisor of 0 or 1 decodes as 2
    function automatic int unsigned eff_divisor(logic [DIVISOR_BITS-1:0] d);
        return (d < DIVISOR_BITS'(2)) ? 32'd2 : 32'(d);
    endfunction

    function automatic int unsigned ceil_log2(int unsigned m);
        int unsigned b = 0;
        while ((64'd1 << b) < 64'(m)) b++;
        return b;
    endfunction

    function automatic void clear_symbol();
        sym_phase  = PH_QUOT;
        sym_qcount = 0;
        sym_acc    = 0;
        sym_bits   = 0;
        sym_hold   = 0;
    endfunction

    function automatic void emit_symbol(longint unsigned v, logic [1:0] st);
        sym_fire   = 1'b1;
        sym_value  = v[VALUE_W-1:0];
        sym_status = st;
        clear_symbol();
    endfunction

    // remainder known: magnitude is q*m + r; zero skips the sign bit
    function automatic void close_remainder(longint unsigned r);
        longint unsigned mag;
        mag = 64'(sym_qcount) * 64'(eff_divisor(div_reg)) + r;
        if (mag > 64'(MAG_LIMIT)) begin
            emit_symbol(64'd0, ST_OVERFLOW);
        end else if (mag == 0) begin
            emit_symbol(64'd0, ST_OK);
        end else begin
            sym_hold  = mag;
            sym_phase = PH_SIGN;
        end
    endfunction

    // b-1 prefix bits in: at or above 2^b-m one more bit follows
    function automatic void close_prefix();
        int unsigned     m = eff_divisor(div_reg);
        longint unsigned lofs = (64'd1 << ceil_log2(m)) - 64'(m);
        if (sym_acc >= lofs) begin
            sym_phase = PH_EXTRA;
        end else begin
            close_remainder(sym_acc);
        end
    endfunction

    // Advance the symbol state by one coded bit; sym_fire flags a result.
    function automatic void decode_bit(logic cbit, logic eos);
        int unsigned     m, b;
        longint unsigned lofs, full;
        sym_fire = 1'b0;
        if (eos) begin
            emit_symbol(64'd0, ST_EOS);
            return;
        end
        m    = eff_divisor(div_reg);
        b    = ceil_log2(m);
        lofs = (64'd1 << b) - 64'(m);
        case (sym_phase)
            PH_QUOT: begin
                if (!cbit) begin
                    if (sym_qcount >= QUOTIENT_MAX) emit_symbol(64'd0, ST_OVERFLOW);
                    else sym_qcount++;
                end else begin
                    sym_acc  = 0;
                    sym_bits = 0;
                    if (b <= 1) close_prefix();
                    else sym_phase = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                sym_acc = {sym_acc[62:0], cbit};
                sym_bits++;
                if (sym_bits + 1 >= b) close_prefix();
            end
            PH_EXTRA: begin
                full = {sym_acc[62:0], cbit};
                close_remainder((full >= lofs) ? full - lofs : 64'd0);
            end
            PH_SIGN: begin
                emit_symbol(cbit ? 64'd0 - sym_hold : sym_hold, ST_OK);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_bit(logic cbit, logic eos);
        pending_beats.push_back('{cbit, eos, 1'b0, '0, ST_OK});
    endfunction

    // Encode one signed symbol under the current divisor.
    function automatic void queue_symbol(longint unsigned mag, logic neg);
        int unsigned     m = eff_divisor(div_reg);
        int unsigned     b = ceil_log2(m);
        longint unsigned lofs = (64'd1 << b) - 64'(m);
        longint unsigned r = mag % 64'(m);
        longint unsigned code;
        int              nbits;
        for (longint unsigned i = 0; i < mag / 64'(m); i++) push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        // truncated binary: short codes below 2^b-m, long codes shifted up
        if (r < lofs) begin
            code  = r;
            nbits = b - 1;
        end else begin
            code  = r + lofs;
            nbits = b;
        end
        for (int i = nbits - 1; i >= 0; i--) push_bit(code[i], 1'b0);
        if (mag != 0) push_bit(neg, 1'b0);
    endfunction

    // Mostly well-formed symbols; some cut off by end of stream; some raw noise.
    function automatic void queue_random_symbol();
        int unsigned     m = eff_divisor(div_reg);
        int unsigned     kind = $urandom_range(0, 99);
        longint unsigned q, mag;
        int              keep;
        if (kind >= 87) begin
            repeat ($urandom_range(1, 6)) begin
                push_bit(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
            end
            return;
        end
        q   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        mag = ($urandom_range(0, 19) == 0) ? 0 : q * m + $urandom_range(0, m - 1);
        queue_symbol(mag, 1'($urandom_range(0, 1)));
        if (kind >= 75) begin
            keep = $urandom_range(0, pending_beats.size() - 1);
            while (pending_beats.size() > keep) void'(pending_beats.pop_back());
            push_bit(1'($urandom_range(0, 1)), 1'b1);
        end
    endfunction

    function automatic bit sender_idles();
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit receiver_stalls();
        int pct;
        pct = (idle_mode == IDLE_RECEIVER) ? 47 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void report_failure(string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: everything moves on the falling edge.
    // ------------------------------------------------------------------

    // Offer one beat and hold it until taken; returns on the accepting rising edge.
    task automatic send_beat(input t_stim_row row);
        @(negedge i_clk);
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_coded_bit     <= row.cbit;
        i_end_of_stream <= row.eos;
        row_has_expect  <= row.has_expect;
        row_expect      <= '{row.value, row.status};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_pending();
        while (pending_beats.size() != 0) begin
            send_beat(pending_beats.pop_front());
            phase_items++;
        end
    endtask

    // Drop valid, let every expected result out, then cover beats still
    // in flight that carry no result.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write only with the block quiet; a half-built symbol may still be
    // pending, which the write must discard.
    task automatic set_divisor(input logic [DIVISOR_BITS-1:0] d);
        quiesce();
        i_divisor_we <= 1'b1;
        i_divisor    <= d;
        @(negedge i_clk);
        i_divisor_we <= 1'b0;
    endtask

    // Result side: random stalls per idle mode, plus one long hold-off on request.
    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= !receiver_stalls();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled on the rising edge. Result check comes
    // before the push, since a result never belongs to the beat taken at
    // the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sym_result got, want;
        cycle_count++;
        if (!i_rst_n) begin
            div_reg = 16'd2;
            clear_symbol();
            expected_symbols.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_value, o_status};
                if (expected_symbols.size() == 0) begin
                    report_failure($sformatf("unexpected result: value %0d status %0d",
                                             o_value, o_status));
                end else begin
                    want = expected_symbols.pop_front();
                    if (got.value !== want.value || got.status !== want.status)
                        report_failure($sformatf(
                            "mismatch: expected value %0d status %0d, got value %0d status %0d",
                            $signed(want.value), want.status, o_value, o_status));
                end
            end
            if (i_divisor_we) begin
                div_reg = i_divisor;
                clear_symbol();
            end
            if (i_in_valid && o_in_ready) begin
                decode_bit(i_coded_bit, i_end_of_stream);
                if (row_has_expect) expected_symbols.push_back(row_expect);
                else if (sym_fire) expected_symbols.push_back('{sym_value, sym_status});
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed rows, all at the reset divisor of 2 (one extra bit, no prefix).
    // Columns: coded bit, end of stream, typed result, value, status.
    // ------------------------------------------------------------------
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{1'b0, 1'b1, 1'b1, 29'sd0, ST_EOS},   // end of stream between symbols
        '{1'b1, 1'b1, 1'b1, 29'sd0, ST_EOS},   // coded bit ignored with end of stream
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b0, 1'b0, 1'b1, 29'sd0, ST_OK},    // zero magnitude, no sign bit
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b0, 1'b0, 1'b1, 29'sd1, ST_OK},    // +1
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b1, -29'sd1, ST_OK},   // -1
        '{1'b0, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b0, 1'b1, 1'b1, 29'sd0, ST_EOS},   // end of stream inside quotient
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b0, 1'b1, 1'b1, 29'sd0, ST_EOS},   // end of stream inside remainder
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b0, 1'b1, 1'b1, 29'sd0, ST_EOS},   // end of stream before sign bit
        '{1'b0, 1'b0, 1'b0, 29'sd0, ST_OK},    // q=2, r=1, negative: predicted
        '{1'b0, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK},
        '{1'b1, 1'b0, 1'b0, 29'sd0, ST_OK}
    };

    // Divisors per phase: odd, both extremes, the two that fall back to 2,
    // powers of two, a random one last.
    logic [DIVISOR_BITS-1:0] phase_divisors [NUM_PHASES] = '{
        16'd3, 16'd65535, 16'd0, 16'd1, 16'd2, 16'd16,
        16'd5, 16'd1000, 16'd32768, 16'd4097, 16'd7, 16'd255
    };

    initial begin : stimulus
        logic [DIVISOR_BITS-1:0] div;
        bit                      pressed;
        int                      keep;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_beat(directed_rows[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            div = (p == NUM_PHASES - 1) ? 16'($urandom) : phase_divisors[p];
            set_divisor(div);
            idle_mode   = t_idle_mode'(p % 4);
            phase_items = 0;
            pressed     = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                queue_random_symbol();
                send_pending();
                // long output stall while beats keep coming: input must back up
                if (p == 3 && !pressed && phase_items >= 20) begin
                    hold_off_req = 1'b1;
                    pressed      = 1'b1;
                end
                // sender sits out until the pipe is empty
                if (p == 6 && !pressed && phase_items >= 40) begin
                    quiesce();
                    pressed = 1'b1;
                end
            end
            // sometimes leave a symbol half done; the next write drops it
            if ($urandom_range(0, 1)) begin
                queue_symbol($urandom_range(1, 200), 1'b0);
                keep = $urandom_range(1, pending_beats.size() - 1);
                while (pending_beats.size() > keep) void'(pending_beats.pop_back());
                send_pending();
            end
        end

        // Largest magnitude at the top divisor (q at its bound, r = m-1),
        // then one zero too many in the quotient for the overflow code.
        set_divisor(16'hFFFF);
        idle_mode = IDLE_NONE;
        queue_symbol(longint'(QUOTIENT_MAX) * 65535 + 65534, 1'b1);
        repeat (QUOTIENT_MAX + 1) push_bit(1'b0, 1'b0);
        send_pending();

        quiesce();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
